// ===== hdl/assert_macros.svh =====
// Shared assertion macros for the sorted list table checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk while rst is low.
`define SLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define SLT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/slt_pkg.sv =====
package slt_pkg;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RM_INDEX  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RM_VALUE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WRITE     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // Number of cells folded together in the first stage of the read tree.
  localparam int RD_GROUP = 16;

  typedef struct packed {
    logic                      apply;
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;
  } slt_ctrl_t;

endpackage

// ===== hdl/slt_cell.sv =====
module slt_cell #(
  parameter int POS   = 0,
  parameter int CNT_W = 9,
  parameter int CMP_W = 9
) (
  input  logic                               clk,
  input  slt_pkg::slt_ctrl_t                 ctrl,
  input  logic [CNT_W-1:0]                   entry_count,
  input  logic signed [slt_pkg::VALUE_W-1:0] prev_word,
  input  logic signed [slt_pkg::VALUE_W-1:0] next_word,
  input  logic                               scan_own,
  input  logic                               scan_prev,
  output logic signed [slt_pkg::VALUE_W-1:0] word,
  output logic                               le,
  output logic                               eq,
  output logic signed [slt_pkg::VALUE_W-1:0] sel_word
);
  import slt_pkg::*;

  localparam logic [CNT_W-1:0] POS_CNT = CNT_W'(POS);
  localparam logic [CMP_W-1:0] POS_CMP = CMP_W'(POS);

  logic                      occupied;
  logic                      upto;
  logic                      at_index;
  logic                      from_index;
  logic [CMP_W-1:0]          index_ext;
  logic signed [VALUE_W-1:0] word_next;

  assign index_ext  = CMP_W'(ctrl.index);
  assign occupied   = POS_CNT < entry_count;
  assign upto       = POS_CNT <= entry_count;
  assign at_index   = POS_CMP == index_ext;
  assign from_index = POS_CMP >= index_ext;

  assign le       = occupied && (word <= ctrl.value);
  assign eq       = occupied && (word == ctrl.value);
  assign sel_word = (occupied && at_index) ? word : '0;

  always_comb begin
    word_next = word;
    if (ctrl.apply) begin
      unique case (ctrl.kind)
        KIND_INSERT: begin
          if (upto) begin
            if (!scan_prev) begin
              word_next = prev_word;
            end else if (!scan_own) begin
              word_next = ctrl.value;
            end
          end
        end
        KIND_RM_INDEX: begin
          if (occupied && from_index) begin
            word_next = next_word;
          end
        end
        KIND_RM_VALUE: begin
          if (occupied && scan_own) begin
            word_next = next_word;
          end
        end
        KIND_WRITE: begin
          if (occupied && at_index) begin
            word_next = ctrl.value;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ===== hdl/slt_scan.sv =====
module slt_scan #(
  parameter int DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             up,
  input  logic [DEPTH-1:0] init,
  output logic [DEPTH-1:0] vec,
  output logic             last
);

  localparam int LEVELS = $clog2(DEPTH);
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  logic [LVL_W-1:0] lvl;
  logic             running;
  logic             dir_up;
  logic [DEPTH-1:0] shifted;

  assign last = running && (lvl == LVL_W'(LEVELS - 1));

  // Each level ORs in the flag a power of two away, so after all levels every
  // bit holds the OR of all flags below it (up) or above it (down).
  always_comb begin
    shifted = '0;
    for (int i = 0; i < DEPTH; i++) begin
      for (int k = 0; k < LEVELS; k++) begin
        if (lvl == LVL_W'(k)) begin
          if (dir_up) begin
            if (i >= (1 << k)) begin
              shifted[i] = vec[i - (1 << k)];
            end
          end else begin
            if (i + (1 << k) < DEPTH) begin
              shifted[i] = vec[i + (1 << k)];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      lvl     <= '0;
    end else if (load) begin
      running <= 1'b1;
      lvl     <= '0;
    end else if (running) begin
      if (last) begin
        running <= 1'b0;
      end else begin
        lvl <= lvl + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vec    <= init;
      dir_up <= up;
    end else if (running) begin
      vec <= vec | shifted;
    end
  end

endmodule

// ===== hdl/sorted_list_table_unit.sv =====
// Flow: a taken word passes the load, scan and apply states; its result is registered as it leaves apply.
// A new word is taken only when idle, after the last one is applied; the doubling OR scan across the
// cell row, which finds the insert point or the first match, takes one level a cycle.
// Reset: synchronous active-high rst empties the table (count zero) and drops any
// pending result; the entry cells themselves are not cleared.
module sorted_list_table_unit #(
  parameter int DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [slt_pkg::KIND_W-1:0]          kind,
  input  logic signed [slt_pkg::VALUE_W-1:0]  value,
  input  logic [slt_pkg::INDEX_W-1:0]         index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [slt_pkg::STATUS_W-1:0]        status,
  output logic signed [slt_pkg::VALUE_W-1:0]  read_value,
  output logic [slt_pkg::COUNT_W-1:0]         count
);
  import slt_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int NGRP  = (DEPTH + RD_GROUP - 1) / RD_GROUP;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOAD  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  logic [1:0]                state;
  logic [1:0]                state_next;
  logic [KIND_W-1:0]         op_kind;
  logic signed [VALUE_W-1:0] op_value;
  logic [INDEX_W-1:0]        op_index;
  logic [CNT_W-1:0]          entry_count;
  logic [CNT_W-1:0]          entry_count_next;
  logic [EXT_W-1:0]          count_ext;

  slt_ctrl_t                 ctrl;
  logic signed [VALUE_W-1:0] words     [DEPTH];
  logic signed [VALUE_W-1:0] sel_words [DEPTH];
  logic [DEPTH-1:0]          le_vec;
  logic [DEPTH-1:0]          eq_vec;
  logic [DEPTH-1:0]          scan_vec;
  logic                      scan_last;
  logic                      scan_load;
  logic                      scan_up;

  logic signed [VALUE_W-1:0] grp_comb [NGRP];
  logic signed [VALUE_W-1:0] grp_word [NGRP];
  logic signed [VALUE_W-1:0] rd_comb;
  logic signed [VALUE_W-1:0] rd_sum;

  logic                      in_range;
  logic                      full;
  logic                      found;
  logic                      fire;
  logic                      op_ok;
  logic [STATUS_W-1:0]       status_next;
  logic signed [VALUE_W-1:0] rd_next;

  assign in_stall  = state != S_IDLE;
  assign in_range  = CMP_W'(op_index) < CMP_W'(entry_count);
  assign full      = entry_count == CNT_W'(DEPTH);
  assign found     = scan_vec[DEPTH-1];
  assign fire      = (state == S_APPLY) && !(out_valid && out_stall);
  assign scan_load = state == S_LOAD;
  assign scan_up   = op_kind != KIND_INSERT;

  assign ctrl.apply = fire && op_ok;
  assign ctrl.kind  = op_kind;
  assign ctrl.value = op_value;
  assign ctrl.index = op_index;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [VALUE_W-1:0] prev_w;
      logic signed [VALUE_W-1:0] next_w;
      logic                      scan_p;

      if (gi == 0) begin : g_first
        assign prev_w = words[gi];
        assign scan_p = 1'b1;
      end else begin : g_mid
        assign prev_w = words[gi-1];
        assign scan_p = scan_vec[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
        assign next_w = words[gi];
      end else begin : g_inner
        assign next_w = words[gi+1];
      end

      slt_cell #(
        .POS   (gi),
        .CNT_W (CNT_W),
        .CMP_W (CMP_W)
      ) u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .entry_count (entry_count),
        .prev_word   (prev_w),
        .next_word   (next_w),
        .scan_own    (scan_vec[gi]),
        .scan_prev   (scan_p),
        .word        (words[gi]),
        .le          (le_vec[gi]),
        .eq          (eq_vec[gi]),
        .sel_word    (sel_words[gi])
      );
    end
  endgenerate

  slt_scan #(
    .DEPTH (DEPTH)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .load (scan_load),
    .up   (scan_up),
    .init (scan_up ? eq_vec : le_vec),
    .vec  (scan_vec),
    .last (scan_last)
  );

  // Two registered stages fold the selected cell onto the read path.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_comb[g] = '0;
      for (int j = 0; j < RD_GROUP; j++) begin
        if (g * RD_GROUP + j < DEPTH) begin
          grp_comb[g] = grp_comb[g] | sel_words[g * RD_GROUP + j];
        end
      end
    end
    rd_comb = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_comb = rd_comb | grp_word[g];
    end
  end

  always_ff @(posedge clk) begin
    grp_word <= grp_comb;
    rd_sum   <= rd_comb;
  end

  always_comb begin
    status_next      = ST_OK;
    rd_next          = '0;
    entry_count_next = entry_count;
    op_ok            = 1'b0;
    unique case (op_kind)
      KIND_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          op_ok            = 1'b1;
          entry_count_next = entry_count + 1'b1;
        end
      end
      KIND_RM_INDEX: begin
        if (!in_range) begin
          status_next = ST_RANGE;
        end else begin
          op_ok            = 1'b1;
          entry_count_next = entry_count - 1'b1;
        end
      end
      KIND_RM_VALUE: begin
        if (!found) begin
          status_next = ST_NOTFOUND;
        end else begin
          op_ok            = 1'b1;
          entry_count_next = entry_count - 1'b1;
        end
      end
      KIND_READ: begin
        if (!in_range) begin
          status_next = ST_RANGE;
        end else begin
          op_ok   = 1'b1;
          rd_next = rd_sum;
        end
      end
      KIND_WRITE: begin
        if (!in_range) begin
          status_next = ST_RANGE;
        end else begin
          op_ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign count_ext = EXT_W'(entry_count_next);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        entry_count <= entry_count_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_kind  <= kind;
      op_value <= value;
      op_index <= index;
    end
    if (fire) begin
      status     <= status_next;
      read_value <= rd_next;
      count      <= count_ext[COUNT_W-1:0];
    end
  end

endmodule

// ===== hdl/slt_checker.sv =====
`include "assert_macros.svh"

module slt_checker #(
  parameter int DEPTH = 256
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [slt_pkg::STATUS_W-1:0]        status,
  input logic signed [slt_pkg::VALUE_W-1:0]  read_value,
  input logic [slt_pkg::COUNT_W-1:0]         count
);
  import slt_pkg::*;

  localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(DEPTH);

  // A failed operation never returns data.
  `SLT_ASSERT(a_fail_zero, out_valid && status != ST_OK |-> read_value == '0, "failed op returned data")

  // A full report only comes from a table at its depth.
  `SLT_ASSERT(a_full_count, out_valid && status == ST_FULL |-> count == DEPTH_CNT, "full with short count")

  // One word is worked on at a time.
  `SLT_ASSERT(a_one_at_a_time, in_valid && !in_stall |=> in_stall, "second word taken while busy")

  // A result never follows its input word in the very next cycle.
  `SLT_ASSERT(a_no_early_result, in_valid && !in_stall && !out_valid |=> !out_valid, "result too early")

  // A held result keeps its payload.
  `SLT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(status) && $stable(read_value) && $stable(count), "stalled result changed")

endmodule

bind sorted_list_table_unit slt_checker #(.DEPTH(DEPTH)) u_slt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .read_value (read_value),
  .count      (count)
);
